// ----- design/sasrrip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRRIP tag store package
// Command and status types shared by the controller and the datapath, and
// the fixed re-reference interval values.
// ----------------------------------------------------------------------------
package sasrrip_pkg;

    localparam logic [1:0] RRV_HIT  = 2'd0;
    localparam logic [1:0] RRV_FILL = 2'd2;
    localparam logic [1:0] RRV_MAX  = 2'd3;

    typedef struct packed {
        logic accept;
        logic mod_step;
        logic rd_en;
        logic lookup;
        logic clear_step;
    } sasrrip_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_skip;
        logic mod_last;
    } sasrrip_stat_t;

endpackage
`default_nettype wire

// ----- design/sasrrip_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sasrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/sasrrip_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRRIP tag store controller
// Sequences the clearing pass, set index reduction, set read and lookup.
// ----------------------------------------------------------------------------
module sasrrip_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire sasrrip_pkg::sasrrip_stat_t stat,
    output sasrrip_pkg::sasrrip_cmd_t       cmd,
    output logic                           busy
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_LOOKUP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (stat.mod_skip)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

// ----- design/sasrrip_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SRRIP tag store datapath
// Address split, set index reduction, metadata RAM, way selection with
// ageing, hit and miss counters and the result registers.
// ----------------------------------------------------------------------------
module sasrrip_dp #(
    parameter int WAYS       = 8,
    parameter int SETS       = 64,
    parameter int LINE_BYTES = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [31:0]               address,
    input  wire sasrrip_pkg::sasrrip_cmd_t  cmd,
    output sasrrip_pkg::sasrrip_stat_t      stat,
    output logic                           done,
    output logic                           hit,
    output logic [2:0]                     way,
    output logic                           evicted_valid,
    output logic [31:0]                    hit_total,
    output logic [31:0]                    miss_total
);

    localparam int OFF_BITS  = $clog2(LINE_BYTES + 1) - 1;
    localparam int IDX_BITS  = $clog2(SETS);
    localparam int TAG_SHIFT = OFF_BITS + IDX_BITS;
    localparam int TAG_W     = 32 - TAG_SHIFT;
    localparam int E_W       = TAG_W + 3;
    localparam int ROW_W     = WAYS * E_W;
    localparam int WAY_W     = $clog2(WAYS);
    localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

    logic [TAG_W-1:0]    tag_reg;
    logic [IDX_BITS-1:0] set_reg;
    logic [IDX_BITS-1:0] clr_reg;
    logic [IDX_BITS-1:0] rd_addr;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    new_row;
    logic                ram_wr_en;
    logic [IDX_BITS-1:0] ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;

    logic [WAYS-1:0]     v;
    logic [TAG_W-1:0]    tg    [WAYS];
    logic [1:0]          rr    [WAYS];
    logic [1:0]          aged  [WAYS];
    logic                hit_any;
    logic [WAY_W-1:0]    hit_idx;
    logic                inv_any;
    logic [WAY_W-1:0]    inv_idx;
    logic [WAY_W-1:0]    victim_idx;
    logic [WAY_W-1:0]    fill_idx;
    logic                any3;
    logic                any2;
    logic                any1;
    logic [1:0]          maxv;
    logic [1:0]          add;

    logic                done_reg;
    logic                hit_reg;
    logic [2:0]          way_reg;
    logic                evicted_reg;
    logic [31:0]         hit_cnt_reg;
    logic [31:0]         miss_cnt_reg;

    generate
        if (SETS_POW2)
        begin : g_mask
            assign rd_addr       = address[OFF_BITS +: IDX_BITS];
            assign stat.mod_skip = 1'b1;
            assign stat.mod_last = 1'b0;
        end
        else
        begin : g_mod
            // The quotient comes from a reciprocal multiplication that is exact
            // for every line address; the remainder is then formed from q_reg into rem_reg.
            localparam int XW = 32 - OFF_BITS;
            localparam int K  = XW + IDX_BITS;
            localparam int RW = XW + 2;
            localparam int PW = XW + RW;
            localparam logic [RW-1:0] RECIP =
                RW'(((64'd1 << K) + 64'(SETS) - 64'd1) / 64'(SETS));

            logic [XW-1:0]       x_reg;
            logic [XW-1:0]       q_reg;
            logic [IDX_BITS-1:0] rem_reg;
            logic                cnt_reg;
            logic [PW-1:0]       prod;
            logic [XW-1:0]       q_sets;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= 1'b0;
                end
                else if (cmd.accept)
                begin
                    cnt_reg <= 1'b0;
                end
                else if (cmd.mod_step)
                begin
                    cnt_reg <= !cnt_reg;
                end
            end

            assign prod   = PW'(x_reg) * PW'(RECIP);
            assign q_sets = q_reg * XW'(SETS);

            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                begin
                    x_reg <= address[OFF_BITS +: XW];
                end
                else if (cmd.mod_step)
                begin
                    if (!cnt_reg)
                    begin
                        q_reg <= XW'(prod >> K);
                    end
                    else
                    begin
                        rem_reg <= IDX_BITS'(x_reg - q_sets);
                    end
                end
            end

            assign rd_addr       = rem_reg;
            assign stat.mod_skip = 1'b0;
            assign stat.mod_last = cnt_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + IDX_BITS'(1);
        end
    end

    assign stat.clear_last = (clr_reg == IDX_BITS'(SETS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tag_reg <= address[TAG_SHIFT +: TAG_W];
        end
        if (cmd.rd_en)
        begin
            set_reg <= rd_addr;
        end
    end

    assign ram_wr_en   = cmd.clear_step | cmd.lookup;
    assign ram_wr_addr = cmd.clear_step ? clr_reg : set_reg;
    assign ram_wr_data = cmd.clear_step ? '0 : new_row;

    sasrrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (row)
    );

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            v[w]    = row[w*E_W + E_W - 1];
            tg[w]   = row[w*E_W + 2 +: TAG_W];
            rr[w]   = row[w*E_W +: 2];
            aged[w] = rr[w] + add;
        end
    end

    always_comb
    begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        inv_any    = 1'b0;
        inv_idx    = '0;
        victim_idx = '0;
        any3       = 1'b0;
        any2       = 1'b0;
        any1       = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (v[w] && (tg[w] == tag_reg))
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!v[w])
            begin
                inv_any = 1'b1;
                inv_idx = WAY_W'(w);
            end
            if (aged[w] == sasrrip_pkg::RRV_MAX)
            begin
                victim_idx = WAY_W'(w);
            end
            any3 = any3 | (rr[w] == 2'd3);
            any2 = any2 | (rr[w] == 2'd2);
            any1 = any1 | (rr[w] == 2'd1);
        end
    end

    assign maxv     = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    assign add      = sasrrip_pkg::RRV_MAX - maxv;
    assign fill_idx = inv_any ? inv_idx : victim_idx;

    always_comb
    begin
        new_row = row;
        if (hit_any)
        begin
            new_row[int'(hit_idx)*E_W +: 2] = sasrrip_pkg::RRV_HIT;
        end
        else
        begin
            if (!inv_any)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    new_row[w*E_W +: 2] = aged[w];
                end
            end
            new_row[int'(fill_idx)*E_W +: E_W] = {1'b1, tag_reg, sasrrip_pkg::RRV_FILL};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.lookup;
            if (cmd.lookup)
            begin
                if (hit_any)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg     <= hit_any;
            way_reg     <= 3'(hit_any ? hit_idx : fill_idx);
            evicted_reg <= !hit_any && !inv_any;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign way           = way_reg;
    assign evicted_valid = evicted_reg;
    assign hit_total     = hit_cnt_reg;
    assign miss_total    = miss_cnt_reg;

endmodule
`default_nettype wire

// ----- design/set_assoc_cache_srrip_tags.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Set-associative cache tag store with 2-bit SRRIP replacement
// Looks up a fetch address, updates valid, tag and re-reference state of the
// set, and reports hit, way, eviction and running hit and miss counts.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          address
//  result    done (one cycle)     hit, way, evicted_valid, hit_total,
//                                 miss_total
//
// With SETS a power of two the set row is read from the metadata RAM on
// acceptance, then compared and written back.
// Otherwise the set index is first reduced modulo SETS by a reciprocal
// multiplication before the set row is read.
// The result appears in the cycle after the lookup, while busy is already low.
// After reset a clearing pass over all SETS rows holds busy high.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module set_assoc_cache_srrip_tags #(
    parameter int WAYS       = 8,
    parameter int SETS       = 64,
    parameter int LINE_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] address,
    output logic             busy,
    output logic             done,
    output logic             hit,
    output logic [2:0]       way,
    output logic             evicted_valid,
    output logic [31:0]      hit_total,
    output logic [31:0]      miss_total
);

    sasrrip_pkg::sasrrip_cmd_t  cmd;
    sasrrip_pkg::sasrrip_stat_t stat;

    sasrrip_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sasrrip_dp #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .address       (address),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .hit           (hit),
        .way           (way),
        .evicted_valid (evicted_valid),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("Result strobe without a transaction in progress.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !evicted_valid)
        else $error("A hit reported an eviction.");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> (hit_total == $past(hit_total) + 32'd1) && $stable(miss_total))
        else $error("Hit count did not advance by one on a hit.");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (miss_total == $past(miss_total) + 32'd1) && $stable(hit_total))
        else $error("Miss count did not advance by one on a miss.");
`endif

endmodule
`default_nettype wire

// ----- dv/srrip_tag_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRRIP tag store checker
// Watches the request and result channels of the tag store. It predicts each
// lookup from its own copy of the valid, tag and re-reference state, and
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module srrip_tag_checker #(
    parameter int WAYS       = 8,
    parameter int SETS       = 64,
    parameter int LINE_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] address,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic        hit,
    input  wire logic [2:0]  way,
    input  wire logic        evicted_valid,
    input  wire logic [31:0] hit_total,
    input  wire logic [31:0] miss_total,
    output int               failures,
    output int               pending
);

    localparam int OFF_BITS    = $clog2(LINE_BYTES + 1) - 1;
    localparam int IDX_BITS    = $clog2(SETS);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic        evicted_valid;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } lookup_result_t;

    logic          line_ok   [SETS][WAYS];
    logic [31:0]   line_tags [SETS][WAYS];
    logic [1:0]    rrv       [SETS][WAYS];
    logic [31:0]   hits_seen;
    logic [31:0]   misses_seen;
    lookup_result_t lookup_queue [$];
    lookup_result_t expected;
    lookup_result_t observed;
    int            mismatches;

    assign failures = mismatches;

    function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
        int unsigned    set_idx;
        logic [31:0]    tag;
        int             match;
        int             victim;
        logic [1:0]     oldest;
        lookup_result_t r;
        set_idx = (addr >> OFF_BITS) % SETS;
        tag     = addr >> (OFF_BITS + IDX_BITS);
        match   = -1;
        victim  = -1;
        r       = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (match < 0 && line_ok[set_idx][w] && line_tags[set_idx][w] == tag)
                match = w;
        end
        if (match >= 0)
        begin
            rrv[set_idx][match] = sasrrip_pkg::RRV_HIT;
            hits_seen = hits_seen + 1;
            r.hit = 1'b1;
            r.way = match[2:0];
        end
        else
        begin
            misses_seen = misses_seen + 1;
            for (int w = 0; w < WAYS; w++)
            begin
                if (victim < 0 && !line_ok[set_idx][w])
                    victim = w;
            end
            if (victim < 0)
            begin
                r.evicted_valid = 1'b1;
                oldest = 2'd0;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (rrv[set_idx][w] > oldest)
                        oldest = rrv[set_idx][w];
                end
                // Age the whole set so that its largest value reaches the maximum.
                if (oldest != sasrrip_pkg::RRV_MAX)
                begin
                    for (int w = 0; w < WAYS; w++)
                        rrv[set_idx][w] = rrv[set_idx][w] + (sasrrip_pkg::RRV_MAX - oldest);
                end
                for (int w = 0; w < WAYS; w++)
                begin
                    if (victim < 0 && rrv[set_idx][w] == sasrrip_pkg::RRV_MAX)
                        victim = w;
                end
                if (victim < 0)
                    victim = 0;
            end
            line_ok[set_idx][victim]   = 1'b1;
            line_tags[set_idx][victim] = tag;
            rrv[set_idx][victim]       = sasrrip_pkg::RRV_FILL;
            r.way = victim[2:0];
        end
        r.hit_total  = hits_seen;
        r.miss_total = misses_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    line_ok[s][w]   = 1'b0;
                    line_tags[s][w] = '0;
                    rrv[s][w]       = '0;
                end
            end
            hits_seen   = '0;
            misses_seen = '0;
            lookup_queue.delete();
            mismatches  = 0;
            pending    <= 0;
        end
        else
        begin
            if (done)
            begin
                observed.hit           = hit;
                observed.way           = way;
                observed.evicted_valid = evicted_valid;
                observed.hit_total     = hit_total;
                observed.miss_total    = miss_total;
                if (lookup_queue.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result with no transaction outstanding: hit=%0d way=%0d",
                                 $time, hit, way);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    expected = lookup_queue.pop_front();
                    if (observed !== expected)
                    begin
                        if (mismatches < MAX_REPORTS)
                        begin
                            $display("%0t: expected hit=%0d way=%0d evicted=%0d hits=%0d misses=%0d",
                                     $time, expected.hit, expected.way,
                                     expected.evicted_valid, expected.hit_total,
                                     expected.miss_total);
                            $display("%0t: actual   hit=%0d way=%0d evicted=%0d hits=%0d misses=%0d",
                                     $time, observed.hit, observed.way,
                                     observed.evicted_valid, observed.hit_total,
                                     observed.miss_total);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                lookup_queue.push_back(predict_lookup(address));
            pending <= lookup_queue.size();
        end
    end

endmodule

// ----- dv/tb_set_assoc_cache_srrip_tags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRRIP tag store testbench
// Drives fetch addresses into the tag store: a directed sequence that fills,
// hits, ages and evicts one set, then random lookups over a small pool of
// sets and tags mixed with fully random addresses, under varying idle rates.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_srrip_tags;

    localparam int WAYS          = 8;
    localparam int SETS          = 64;
    localparam int LINE_BYTES    = 64;
    localparam int OFF_BITS      = $clog2(LINE_BYTES + 1) - 1;
    localparam int IDX_BITS      = $clog2(SETS);
    localparam int TAG_POOL      = 12;
    localparam int SET_POOL      = 4;
    localparam int PHASE_ITEMS   = 200;
    localparam int CYCLE_LIMIT   = 200000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic [31:0] address = '0;
    logic        busy;
    logic        done;
    logic        hit;
    logic [2:0]  way;
    logic        evicted_valid;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    int          failures;
    int          pending;
    int          cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    set_assoc_cache_srrip_tags #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .address       (address),
        .busy          (busy),
        .done          (done),
        .hit           (hit),
        .way           (way),
        .evicted_valid (evicted_valid),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

    srrip_tag_checker #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .address       (address),
        .busy          (busy),
        .done          (done),
        .hit           (hit),
        .way           (way),
        .evicted_valid (evicted_valid),
        .hit_total     (hit_total),
        .miss_total    (miss_total),
        .failures      (failures),
        .pending       (pending)
    );

    function automatic logic [31:0] line_address(input logic [31:0] tag,
                                                 input int unsigned set_idx,
                                                 input int unsigned offset);
        return (tag << (OFF_BITS + IDX_BITS)) | (set_idx << OFF_BITS) | offset;
    endfunction

    // Holds start until the transaction is taken, then idles at the given rate.
    task automatic send_fetch(input logic [31:0] addr, input int idle_pct);
        start   <= 1'b1;
        address <= addr;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_set_assoc_cache_srrip_tags: errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] tag_pool [TAG_POOL];
        int unsigned set_pool [SET_POOL];
        int          idle_levels [4];
        int          rehit_tags [8];
        logic [31:0] addr;

        idle_levels = '{0, 50, 37, 0};
        rehit_tags  = '{9, 10, 3, 4, 5, 6, 7, 8};
        for (int i = 0; i < TAG_POOL; i++)
            tag_pool[i] = $urandom() >> (OFF_BITS + IDX_BITS);
        for (int i = 0; i < SET_POOL; i++)
            set_pool[i] = $urandom_range(0, SETS - 1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_fetch(32'h0000_0000, 0);
        send_fetch(32'hFFFF_FFFF, 0);
        send_fetch(32'h0000_003F, 0);
        send_fetch(32'hFFFF_FFC0, 0);
        for (int t = 1; t <= WAYS; t++)
            send_fetch(line_address(t, 5, t), 0);
        send_fetch(line_address(3, 5, 0), 0);
        // The set is full with no way at the maximum value, so it ages first.
        send_fetch(line_address(9, 5, 0), 0);
        send_fetch(line_address(10, 5, 0), 0);
        for (int i = 0; i < 8; i++)
            send_fetch(line_address(rehit_tags[i], 5, 0), 0);
        // Every way has just been hit, so ageing lifts all of them to the maximum.
        send_fetch(line_address(11, 5, 0), 0);
        send_fetch(line_address(11, 5, LINE_BYTES - 1), 0);

        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 75)
                    addr = line_address(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                                        set_pool[$urandom_range(0, SET_POOL - 1)],
                                        $urandom_range(0, LINE_BYTES - 1));
                else
                    addr = $urandom();
                send_fetch(addr, idle_levels[p]);
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("tb_set_assoc_cache_srrip_tags: clean");
        else
            $display("tb_set_assoc_cache_srrip_tags: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sasrrip_pkg.sv
design/sasrrip_ram.sv
design/sasrrip_ctrl.sv
design/sasrrip_dp.sv
design/set_assoc_cache_srrip_tags.sv
dv/srrip_tag_checker.sv
dv/tb_set_assoc_cache_srrip_tags.sv
